// ===== hw/rtl/lzwd_pkg.sv =====
// lzwd_pkg: constants, types and helper functions of the lzss window decoder
// used by hw/rtl/lzss_window_decoder.sv; depends on nothing else
package lzwd_pkg;

   // window and token geometry
   localparam int MAX_WINDOW_BITS = 11;
   localparam int MAX_LENGTH_BITS = 4;
   localparam int ADDR_W          = MAX_WINDOW_BITS;
   localparam int WIN_DEPTH       = 1 << MAX_WINDOW_BITS;
   localparam int BYTE_BITS       = 8;
   localparam int LIT_TOKEN_BITS  = BYTE_BITS + 1;
   localparam int TOKEN_BITS      = 1 + MAX_WINDOW_BITS + MAX_LENGTH_BITS;
   localparam int TOK_IDX_W       = $clog2(TOKEN_BITS);
   localparam int HELD_W          = $clog2(TOKEN_BITS + BYTE_BITS);
   localparam int MAX_MATCH       = (1 << MAX_LENGTH_BITS) + 1;
   localparam int CNT_W           = $clog2(MAX_MATCH + 1);
   localparam int MIN_MATCH       = 2;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WB_W       = 4;
   localparam int LB_W       = 3;
   localparam logic [WB_W-1:0] WB_RESET = WB_W'(11);
   localparam logic [LB_W-1:0] LB_RESET = LB_W'(4);
   localparam logic REG_WINDOW_BITS = 1'b0;
   localparam logic REG_LENGTH_BITS = 1'b1;

   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [BYTE_BITS-1:0]  byte_type;
   typedef logic [TOKEN_BITS-1:0] token_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   // window_bits clamped to the supported range
   function automatic logic [WB_W-1:0] eff_wb(input logic [WB_W-1:0] wb);
      logic [WB_W-1:0] w;
      w = wb;
      if (w < WB_W'(8)) w = WB_W'(8);
      if (w > WB_W'(MAX_WINDOW_BITS)) w = WB_W'(MAX_WINDOW_BITS);
      return w;
   endfunction

   // length_bits clamped to the supported range
   function automatic logic [LB_W-1:0] eff_lb(input logic [LB_W-1:0] lb);
      logic [LB_W-1:0] l;
      l = lb;
      if (l < LB_W'(2)) l = LB_W'(2);
      if (l > LB_W'(MAX_LENGTH_BITS)) l = LB_W'(MAX_LENGTH_BITS);
      return l;
   endfunction

   // address mask of a window of 2^wbe entries
   function automatic addr_type win_mask(input logic [WB_W-1:0] wbe);
      return ~({ADDR_W{1'b1}} << wbe);
   endfunction

   // write pointer after a restart: window size minus longest match
   function automatic addr_type restart_pos(input logic [WB_W-1:0] wb,
                                            input logic [LB_W-1:0] lb);
      logic [ADDR_W:0] n;
      logic [ADDR_W:0] f;
      n = (ADDR_W+1)'(1) << eff_wb(wb);
      f = ((ADDR_W+1)'(1) << eff_lb(lb)) + (ADDR_W+1)'(1);
      return ADDR_W'(n - f);
   endfunction

endpackage

// ===== hw/rtl/lzwd_ram.sv =====
// lzwd_ram: generic single-clock ram, one write port, one registered read port
// stand-alone; instanced by lzss_window_decoder for the sliding window
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lzss_window_decoder.sv =====
// lzss_window_decoder: lzss token decoder over a sliding window held in ram
// depends on hw/rtl/lzwd_pkg.sv and hw/rtl/lzwd_ram.sv
//
//  channel  direction  handshake          payload
//  req      in         req_valid/ready    req_in_byte
//  rsp      out        rsp_valid/ready    rsp_out_byte, rsp_last
//  csr      in/out     apb psel/penable   paddr, pwdata, prdata
//
// an input word that completes no token leaves the collector ready; one that completes a
// token keeps req_ready low until its last decoded byte issues (1 for a literal, 2..17
// for a match), set by the single read port of the window ram, one byte read per cycle
// while the output is not stalled. after reset and after every register write the
// whole window of 2048 entries is zeroed, during which req_ready stays low.
// a stall on rsp holds the output register and the read stage behind it.
module lzss_window_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_in_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lzwd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lzwd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lzwd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   // configuration registers
   logic [lzwd_pkg::WB_W-1:0] wb_ff, wb_in;
   logic [lzwd_pkg::LB_W-1:0] lb_ff, lb_in;
   logic [lzwd_pkg::WB_W-1:0] wbe;
   logic [lzwd_pkg::LB_W-1:0] lbe;
   lzwd_pkg::addr_type        mask;

   // clearing pass
   logic                clr_ff, clr_in;
   lzwd_pkg::addr_type  clr_addr_ff, clr_addr_in;

   // token collector and write pointer
   lzwd_pkg::token_type              tok_ff, tok_in;
   logic [lzwd_pkg::HELD_W-1:0]      held_ff, held_in;
   lzwd_pkg::addr_type               wp_ff, wp_in;

   // copy engine
   lzwd_pkg::cnt_type   cnt_ff, cnt_in;
   lzwd_pkg::addr_type  ra_ff, ra_in;
   logic                lit_ff, lit_in;
   lzwd_pkg::byte_type  lit_data_ff, lit_data_in;

   // read stage
   logic                b_valid_ff, b_valid_in;
   logic                b_sel_ff, b_sel_in;
   lzwd_pkg::byte_type  b_data_ff, b_data_in;
   logic                b_last_ff, b_last_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   lzwd_pkg::byte_type  rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;

   // handshakes and datapath
   logic                cfg_wr;
   logic                accept;
   logic                out_free;
   logic                b_advance;
   logic                issue;
   lzwd_pkg::byte_type  b_byte;
   lzwd_pkg::byte_type  ram_rd_data;
   logic                ram_wr_en;
   lzwd_pkg::addr_type  ram_wr_addr;
   lzwd_pkg::byte_type  ram_wr_data;

   // collector decode of the incoming word
   logic [lzwd_pkg::TOK_IDX_W-1:0] hm1;
   logic                           flag;
   logic [lzwd_pkg::HELD_W-1:0]    need;
   logic [lzwd_pkg::HELD_W-1:0]    rem;
   logic                           done;
   lzwd_pkg::token_type            full;
   lzwd_pkg::token_type            lmask;
   lzwd_pkg::cnt_type              match_len;
   lzwd_pkg::addr_type             match_pos;

   // effective settings
   assign wbe  = lzwd_pkg::eff_wb(wb_ff);
   assign lbe  = lzwd_pkg::eff_lb(lb_ff);
   assign mask = lzwd_pkg::win_mask(wbe);

   // apb port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         lzwd_pkg::REG_WINDOW_BITS: csr_prdata = lzwd_pkg::CSR_DATA_W'(wb_ff);
         lzwd_pkg::REG_LENGTH_BITS: csr_prdata = lzwd_pkg::CSR_DATA_W'(lb_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // handshakes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign b_advance = b_valid_ff && out_free;
   assign issue     = (cnt_ff != '0) && (!b_valid_ff || b_advance);
   assign req_ready = !clr_ff &&
                      ((cnt_ff == '0) || ((cnt_ff == lzwd_pkg::CNT_W'(1)) && issue));
   assign accept    = req_valid && req_ready;

   // byte leaving the read stage: registered literal or forward, else ram data
   assign b_byte = b_sel_ff ? b_data_ff : ram_rd_data;

   // token completion within this word
   always_comb begin
      hm1  = lzwd_pkg::TOK_IDX_W'(held_ff - 1'b1);
      flag = tok_ff[hm1];
      need = flag ? lzwd_pkg::HELD_W'(lzwd_pkg::LIT_TOKEN_BITS)
                  : lzwd_pkg::HELD_W'(wbe) + lzwd_pkg::HELD_W'(lbe)
                    + lzwd_pkg::HELD_W'(1);
      rem  = need - held_ff;
      done = (held_ff != '0) && (rem <= lzwd_pkg::HELD_W'(lzwd_pkg::BYTE_BITS));
      full = (tok_ff << rem)
             | lzwd_pkg::TOKEN_BITS'(req_in_byte >> (4'(lzwd_pkg::BYTE_BITS) - rem[3:0]));
      lmask     = ~({lzwd_pkg::TOKEN_BITS{1'b1}} << lbe);
      match_len = lzwd_pkg::CNT_W'(full & lmask) + lzwd_pkg::CNT_W'(lzwd_pkg::MIN_MATCH);
      match_pos = lzwd_pkg::ADDR_W'(full >> lbe) & mask;
   end

   // next state
   always_comb begin
      wb_in        = wb_ff;
      lb_in        = lb_ff;
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      tok_in       = tok_ff;
      held_in      = held_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      ra_in        = ra_ff;
      lit_in       = lit_ff;
      lit_data_in  = lit_data_ff;
      b_valid_in   = b_valid_ff;
      b_sel_in     = b_sel_ff;
      b_data_in    = b_data_ff;
      b_last_in    = b_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      // zeroing sweep over the whole window
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == lzwd_pkg::ADDR_W'(lzwd_pkg::WIN_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end

      // output register
      if (out_free) begin
         rsp_valid_in = b_valid_ff;
         rsp_byte_in  = b_byte;
         rsp_last_in  = b_last_ff;
      end

      // byte written back into the window as it moves on
      if (b_advance) begin
         wp_in      = (wp_ff + 1'b1) & mask;
         b_valid_in = 1'b0;
      end

      // issue one byte of the current token into the read stage
      if (issue) begin
         b_valid_in = 1'b1;
         b_last_in  = (cnt_ff == lzwd_pkg::CNT_W'(1));
         b_sel_in   = lit_ff || (b_advance && (wp_ff == ra_ff));
         b_data_in  = lit_ff ? lit_data_ff : b_byte;
         cnt_in     = cnt_ff - 1'b1;
         ra_in      = (ra_ff + 1'b1) & mask;
      end

      // collector update on an accepted word
      if (accept) begin
         if (done) begin
            tok_in  = lzwd_pkg::TOKEN_BITS'(req_in_byte & (8'hFF >> rem[3:0]));
            held_in = lzwd_pkg::HELD_W'(lzwd_pkg::BYTE_BITS) - rem;
            if (flag) begin
               cnt_in      = lzwd_pkg::CNT_W'(1);
               lit_in      = 1'b1;
               lit_data_in = full[7:0];
            end else begin
               cnt_in = match_len;
               ra_in  = match_pos;
               lit_in = 1'b0;
            end
         end else begin
            tok_in  = lzwd_pkg::TOKEN_BITS'({tok_ff, req_in_byte});
            held_in = held_ff + lzwd_pkg::HELD_W'(lzwd_pkg::BYTE_BITS);
         end
      end

      // register write restarts the stream
      if (cfg_wr) begin
         unique case (csr_paddr[2])
            lzwd_pkg::REG_WINDOW_BITS: wb_in = csr_pwdata[lzwd_pkg::WB_W-1:0];
            lzwd_pkg::REG_LENGTH_BITS: lb_in = csr_pwdata[lzwd_pkg::LB_W-1:0];
            default: ;
         endcase
         clr_in      = 1'b1;
         clr_addr_in = '0;
         tok_in      = '0;
         held_in     = '0;
         wp_in       = lzwd_pkg::restart_pos(wb_in, lb_in);
      end
   end

   // registers: control cleared by reset, payload just loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff        <= lzwd_pkg::WB_RESET;
         lb_ff        <= lzwd_pkg::LB_RESET;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         tok_ff       <= '0;
         held_ff      <= '0;
         wp_ff        <= lzwd_pkg::restart_pos(lzwd_pkg::WB_RESET, lzwd_pkg::LB_RESET);
         cnt_ff       <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wb_ff        <= wb_in;
         lb_ff        <= lb_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         tok_ff       <= tok_in;
         held_ff      <= held_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff       <= ra_in;
      lit_ff      <= lit_in;
      lit_data_ff <= lit_data_in;
      b_sel_ff    <= b_sel_in;
      b_data_ff   <= b_data_in;
      b_last_ff   <= b_last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // window ram: sweep writes during clearing, decoded bytes otherwise
   assign ram_wr_en   = clr_ff || b_advance;
   assign ram_wr_addr = clr_ff ? clr_addr_ff : wp_ff;
   assign ram_wr_data = clr_ff ? '0 : b_byte;

   lzwd_ram #(
      .WIDTH (lzwd_pkg::BYTE_BITS),
      .DEPTH (lzwd_pkg::WIN_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue && !lit_ff),
      .rd_addr (ra_ff),
      .rd_data (ram_rd_data)
   );

   // no word taken while the window is being cleared
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_ready)
      else $error("word accepted during window clear");

   // a byte in the read stage is never dropped while the output is stalled
   a_read_stage_held : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !out_free) |=> (b_valid_ff && $stable(b_last_ff)))
      else $error("read stage lost a byte under stall");

   // copy count never exceeds the longest match
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= lzwd_pkg::CNT_W'(lzwd_pkg::MAX_MATCH))
      else $error("copy count out of range");

   // a register write starts a clearing pass
   a_cfg_clears : assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (clr_ff && (clr_addr_ff == '0)))
      else $error("register write did not restart the window");

endmodule

// ===== tb/sv/lzwd_check_pkg.sv =====
// lzwd_check_pkg: scoreboard class that predicts and checks the decoded words
// of the lzss window decoder; depends on hw/rtl/lzwd_pkg.sv for sizes and types
package lzwd_check_pkg;
   import lzwd_pkg::*;

   // smallest usable register settings, larger ones come from lzwd_pkg
   localparam int unsigned MIN_WINDOW_BITS = 8;
   localparam int unsigned MIN_LENGTH_BITS = 2;

   typedef struct packed {
      byte_type data;
      logic     last;
   } decoded_byte_t;

   class decoded_byte_scoreboard;
      byte_type        history [WIN_DEPTH];
      addr_type        write_ptr;
      token_type       token_acc;
      int unsigned     token_len;
      logic [WB_W-1:0] window_bits_reg;
      logic [LB_W-1:0] length_bits_reg;
      decoded_byte_t   expected_bytes [$];
      int unsigned     mismatches;

      function new();
         mismatches      = 0;
         window_bits_reg = WB_RESET;
         length_bits_reg = LB_RESET;
         restart_stream();
      endfunction

      // register values as the decoder uses them, clamped to the legal range
      function int unsigned window_width();
         int unsigned w;
         w = window_bits_reg;
         if (w < MIN_WINDOW_BITS) w = MIN_WINDOW_BITS;
         if (w > MAX_WINDOW_BITS) w = MAX_WINDOW_BITS;
         return w;
      endfunction

      function int unsigned length_width();
         int unsigned l;
         l = length_bits_reg;
         if (l < MIN_LENGTH_BITS) l = MIN_LENGTH_BITS;
         if (l > MAX_LENGTH_BITS) l = MAX_LENGTH_BITS;
         return l;
      endfunction

      function addr_type addr_mask();
         return addr_type'((1 << window_width()) - 1);
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      // empty window and collector, pointer one longest match below the top
      function void restart_stream();
         int unsigned i;
         for (i = 0; i < WIN_DEPTH; i++) history[i] = '0;
         write_ptr = addr_type'((1 << window_width()) - ((1 << length_width()) + 1))
                     & addr_mask();
         token_acc = '0;
         token_len = 0;
      endfunction

      // every register write starts a fresh stream
      function void write_register(input logic index, input logic [CSR_DATA_W-1:0] value);
         if (index == REG_WINDOW_BITS) begin
            window_bits_reg = value[WB_W-1:0];
         end else begin
            length_bits_reg = value[LB_W-1:0];
         end
         restart_stream();
      endfunction

      function void emit_byte(input byte_type value);
         decoded_byte_t item;
         item.data = value;
         item.last = 1'b0;
         expected_bytes.push_back(item);
         history[write_ptr] = value;
         write_ptr = (write_ptr + addr_type'(1)) & addr_mask();
      endfunction

      // shift one compressed word in, msb first, and queue what it decodes to
      function void note_input_byte(input byte_type in_byte);
         int unsigned   ww, lw, need, code, count, i, k;
         addr_type      mask, pos;
         logic          flag;
         decoded_byte_t tail;
         ww    = window_width();
         lw    = length_width();
         mask  = addr_mask();
         count = 0;
         for (i = 0; i < BYTE_BITS; i++) begin
            token_acc = {token_acc[TOKEN_BITS-2:0], in_byte[BYTE_BITS-1-i]};
            token_len++;
            flag = token_acc[token_len-1];
            need = flag ? LIT_TOKEN_BITS : 1 + ww + lw;
            if (token_len >= need) begin
               if (flag) begin
                  emit_byte(token_acc[BYTE_BITS-1:0]);
                  count++;
               end else begin
                  // copy may read bytes written earlier in the same copy
                  code = token_acc & ((1 << lw) - 1);
                  pos  = addr_type'(token_acc >> lw) & mask;
                  for (k = 0; k < code + MIN_MATCH; k++) begin
                     emit_byte(history[(pos + addr_type'(k)) & mask]);
                     count++;
                  end
               end
               token_acc = '0;
               token_len = 0;
            end
         end
         // mark the final word caused by this input
         if (count > 0) begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
         end
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      task check_decoded_byte(input byte_type data, input logic last);
         decoded_byte_t want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("word %02h last %0b with nothing expected", data, last));
            return;
         end
         want = expected_bytes.pop_front();
         if (data !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h", data, want.data));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b on word %02h",
                                      last, want.last, want.data));
         end
      endtask

      task report_leftovers();
         if (expected_bytes.size() > 0) begin
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_bytes.size()));
         end
      endtask
   endclass

endpackage

// ===== tb/sv/lzss_window_decoder_test.sv =====
// lzss_window_decoder_test: top level that drives token streams into the decoder
// depends on hw/rtl/lzwd_pkg.sv, the decoder rtl and tb/sv/lzwd_check_pkg.sv
module lzss_window_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lzwd_pkg::*;
   import lzwd_check_pkg::*;

   localparam int unsigned HALF_PERIOD      = 4;
   localparam int unsigned RESET_CYCLES     = 8;
   localparam int unsigned TIMEOUT_NS       = 4_000_000;
   localparam int unsigned LONG_HOLD_CYCLES = 500;
   localparam int unsigned SETTLE_CYCLES    = 40;
   localparam int unsigned DRAIN_LIMIT      = 50_000;
   localparam int unsigned CSR_STRIDE_SHIFT = 2;
   localparam int unsigned NOISE_WORDS      = 5;
   localparam int unsigned FIRST_WORDS      = 40;
   localparam int unsigned PHASE_WORDS      = 30;
   localparam int          HOLD_AT_WORD     = 20;
   localparam int unsigned NUM_SETTINGS     = 6;

   typedef enum int unsigned {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_mode_t;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_in_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                  hold_request = 1'b0;

   decoded_byte_scoreboard decoder_check;

   // stream under construction for the current register setting
   logic          stream_bits [$];
   byte_type      phase_bytes [$];
   int unsigned   gen_ww;
   int unsigned   gen_lw;
   addr_type      gen_mask;
   addr_type      gen_ptr;

   // settings after the reset one: extremes, then clamped values, then a middle one
   int unsigned   wb_plan [NUM_SETTINGS] = '{8, 11, 8, 3, 15, 9};
   int unsigned   lb_plan [NUM_SETTINGS] = '{2, 2, 4, 0, 7, 3};

   lzss_window_decoder i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   // clock
   always begin
      clock = 1'b0;
      #(HALF_PERIOD);
      clock = 1'b1;
      #(HALF_PERIOD);
   end

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) decoder_check.note_input_byte(req_in_byte);
         if (rsp_valid && rsp_ready) decoder_check.check_decoded_byte(rsp_out_byte, rsp_last);
      end
   end

   // receiver: runs of different ready patterns, plus one long hold on request
   initial begin : receiver
      ready_mode_t mode;
      int unsigned run, k;
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            mode = ready_mode_t'($urandom_range(0, 2));
            run  = $urandom_range(4, 40);
            for (k = 0; k < run && !hold_request; k++) begin
               case (mode)
                  READY_ALWAYS: begin
                     rsp_ready <= 1'b1;
                  end
                  READY_HALF: begin
                     rsp_ready <= 1'($urandom_range(0, 1));
                  end
                  default: begin
                     rsp_ready <= ($urandom_range(0, 3) == 0);
                  end
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // token stream building
   function automatic void push_field(input int unsigned value, input int unsigned width);
      int unsigned i;
      for (i = width; i > 0; i--) stream_bits.push_back(1'(value >> (i - 1)));
   endfunction

   function automatic void add_literal(input byte_type value);
      stream_bits.push_back(1'b1);
      push_field(value, BYTE_BITS);
      gen_ptr = (gen_ptr + addr_type'(1)) & gen_mask;
   endfunction

   function automatic void add_match(input addr_type pos, input int unsigned code);
      stream_bits.push_back(1'b0);
      push_field(pos & gen_mask, gen_ww);
      push_field(code, gen_lw);
      gen_ptr = (gen_ptr + addr_type'(code + MIN_MATCH)) & gen_mask;
   endfunction

   // matches mostly point just behind the write pointer so copies overlap
   function automatic void add_random_token();
      int unsigned pick, code;
      addr_type    pos;
      if ($urandom_range(0, 1)) begin
         add_literal(byte_type'($urandom));
      end else begin
         code = $urandom_range(0, (1 << gen_lw) - 1);
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            pos = gen_ptr - addr_type'($urandom_range(1, (1 << gen_lw) + 1));
         end else if (pick < 7) begin
            pos = gen_ptr - addr_type'($urandom_range(1, 64));
         end else if (pick < 9) begin
            pos = addr_type'($urandom);
         end else begin
            pos = $urandom_range(0, 1) ? gen_mask : '0;
         end
         add_match(pos, code);
      end
   endfunction

   function automatic void begin_phase();
      stream_bits.delete();
      phase_bytes.delete();
      gen_ww   = decoder_check.window_width();
      gen_lw   = decoder_check.length_width();
      gen_mask = decoder_check.addr_mask();
      gen_ptr  = decoder_check.write_ptr;
   endfunction

   // random tail bits leave a cut token behind, then a few noise words
   function automatic void pack_stream(input int unsigned target_words);
      int unsigned i, b;
      byte_type    word;
      while (stream_bits.size() < target_words * BYTE_BITS) add_random_token();
      while (stream_bits.size() % BYTE_BITS != 0) stream_bits.push_back(1'($urandom));
      for (i = 0; i < stream_bits.size(); i += BYTE_BITS) begin
         for (b = 0; b < BYTE_BITS; b++) word[BYTE_BITS-1-b] = stream_bits[i+b];
         phase_bytes.push_back(word);
      end
      repeat (NOISE_WORDS) phase_bytes.push_back(byte_type'($urandom));
   endfunction

   // sender: bursts of random length with random gaps, called at a falling edge
   task automatic send_words(input int hold_at);
      int          n;
      int unsigned burst_left, gap;
      burst_left = $urandom_range(1, 16);
      for (n = 0; n < phase_bytes.size(); n++) begin
         if (n == hold_at) hold_request = 1'b1;
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 16);
         end
         req_valid   <= 1'b1;
         req_in_byte <= phase_bytes[n];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
         burst_left--;
      end
      req_valid <= 1'b0;
   endtask

   // apb write: setup, access, then back to idle
   task automatic write_register(input logic index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(index) << CSR_STRIDE_SHIFT;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      decoder_check.write_register(index, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // wait for every expected word, then let a word with no output settle
   task automatic wait_idle();
      int unsigned waited;
      waited = 0;
      while (decoder_check.pending() > 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // main sequence
   initial begin
      int unsigned p;
      decoder_check = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting: literal extremes, overlapping copy across the pointer wrap,
      // read wrapping at the top of the window, copy of never written entries
      begin_phase();
      add_literal(8'h00);
      add_literal(8'hFF);
      add_literal(8'hA5);
      add_match(gen_ptr - addr_type'(3), (1 << gen_lw) - 1);
      add_match(gen_mask, 1);
      add_match(gen_mask >> 1, 0);
      add_literal(8'h5A);
      add_match(gen_ptr - addr_type'(1), 2);
      add_literal(8'h80);
      add_match('0, 0);
      pack_stream(FIRST_WORDS);
      send_words(HOLD_AT_WORD);
      wait_idle();

      // further settings, each write restarting the stream
      for (p = 0; p < NUM_SETTINGS; p++) begin
         write_register(REG_WINDOW_BITS, ($urandom << WB_W) | wb_plan[p]);
         write_register(REG_LENGTH_BITS, ($urandom << LB_W) | lb_plan[p]);
         begin_phase();
         pack_stream(PHASE_WORDS);
         send_words(-1);
         wait_idle();
      end

      decoder_check.report_leftovers();
      if (decoder_check.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
